FILE: src/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea package
// shared types and constants of the xtea cipher pipeline
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam logic [31:0] Delta    = 32'h9E37_79B9;
  localparam int unsigned SumShift = 11;
  localparam int unsigned RcWidth  = 7;
  localparam int unsigned CfgIdxW  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegKey0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRound = 3'd4;

  // operation codes
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } xtea_in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } xtea_out_t;

  // word travelling through the round stages
  typedef struct packed {
    logic        op;
    logic        active;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } xtea_stage_t;

  function automatic logic [31:0] mix(input logic [31:0] w);
    mix = ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

FILE: src/xtea_if.sv
// ----------------------------------------------------------------------------
// xtea stream interfaces
// valid/ready channels carrying input and result words
// ----------------------------------------------------------------------------
interface xtea_in_if;
  logic                valid;
  logic                ready;
  xtea_pkg::xtea_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xtea_out_if;
  logic                valid;
  logic                ready;
  xtea_pkg::xtea_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/xtea_round.sv
// ----------------------------------------------------------------------------
// xtea round stage
// one registered half round; advance gates the whole pipeline
// ----------------------------------------------------------------------------
module xtea_round #(
  parameter int unsigned Idx = 0,
  parameter bit          Second = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 valid_i,
  input  xtea_pkg::xtea_stage_t stage_i,
  input  logic [127:0]         key_i,
  input  logic [6:0]           rounds_i,
  output logic                 valid_o,
  output xtea_pkg::xtea_stage_t stage_o
);
  import xtea_pkg::*;

  logic        valid_q;
  xtea_stage_t stage_d, stage_q;
  logic [31:0] ksum, kterm;
  logic [1:0]  sel;
  logic        act;

  // round is live while its index is below the round count
  assign act = stage_i.active && ({1'b0, rounds_i} > 8'(Idx));

  always_comb begin
    stage_d = stage_i;
    sel     = 2'd0;
    if (stage_i.op == OpEncrypt) begin
      if (!Second) begin
        sel = stage_i.sum[1:0];
      end else begin
        sel = stage_i.sum[SumShift+1:SumShift];
      end
    end else begin
      if (!Second) begin
        sel = stage_i.sum[SumShift+1:SumShift];
      end else begin
        sel = stage_i.sum[1:0];
      end
    end
    kterm = key_i[32*sel +: 32];
    ksum  = stage_i.sum + kterm;
    if (act) begin
      if (stage_i.op == OpEncrypt) begin
        if (!Second) begin
          stage_d.v0  = stage_i.v0 + (mix(stage_i.v1) ^ ksum);
          stage_d.sum = stage_i.sum + Delta;
        end else begin
          stage_d.v1  = stage_i.v1 + (mix(stage_i.v0) ^ ksum);
        end
      end else begin
        if (!Second) begin
          stage_d.v1  = stage_i.v1 - (mix(stage_i.v0) ^ ksum);
          stage_d.sum = stage_i.sum - Delta;
        end else begin
          stage_d.v0  = stage_i.v0 - (mix(stage_i.v1) ^ ksum);
        end
      end
    end
    stage_d.active = act;
  end

  // stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

FILE: src/xtea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// xtea block cipher unit
// unrolled xtea pipeline, while unstalled one block per cycle
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_if     in   op, word_first, word_second
// out_if    out  result_first, result_second
//
// one block accepted per cycle while the skid word is empty; the path has one
// register per half round plus the entry and output registers
// reset clears all valid bits, keys to zero and round count to 64
// (or MAX_ROUNDS if that is smaller)
// a stalled output word fills one skid word, then the whole pipeline holds
// input ready depends on registered state only; nothing is dropped
module xtea_block_cipher_unit #(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  xtea_in_if.sink                      in_if,
  xtea_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_data_i
);
  import xtea_pkg::*;

  localparam int unsigned Stages = 2 * MAX_ROUNDS;
  localparam logic [RcWidth-1:0] RcReset =
    (MAX_ROUNDS < 64) ? RcWidth'(MAX_ROUNDS) : RcWidth'(64);

  logic [127:0]        key_q;
  logic [RcWidth-1:0]  rounds_q;
  logic                advance;
  logic                valid_s [Stages+1];
  xtea_stage_t         stage_s [Stages+1];
  logic                in_valid_q;
  xtea_stage_t         in_stage_q;
  logic                out_valid_q;
  xtea_out_t           out_data_q;
  logic                skid_valid_q;
  xtea_out_t           skid_data_q;
  logic                out_take;
  logic [31:0]         dec_sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= RcReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0:  key_q[31:0]   <= cfg_data_i;
        RegKey1:  key_q[63:32]  <= cfg_data_i;
        RegKey2:  key_q[95:64]  <= cfg_data_i;
        RegKey3:  key_q[127:96] <= cfg_data_i;
        RegRound: begin
          if ({25'd0, cfg_data_i[6:0]} <= 32'(MAX_ROUNDS)) begin
            rounds_q <= cfg_data_i[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the skid word is occupied
  assign out_take    = out_valid_q && out_if.ready;
  assign advance     = !skid_valid_q;
  assign in_if.ready = advance;

  // decrypt start sum, delta times round count (shift-add over 7 bits)
  always_comb begin
    dec_sum = '0;
    for (int b = 0; b < RcWidth; b++) begin
      if (rounds_q[b]) dec_sum = dec_sum + (Delta << b);
    end
  end

  // entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_stage_q.op          <= in_if.data.op;
      in_stage_q.active      <= 1'b1;
      in_stage_q.v0          <= in_if.data.word_first;
      in_stage_q.v1          <= in_if.data.word_second;
      in_stage_q.sum         <= (in_if.data.op == OpDecrypt) ? dec_sum : 32'd0;
    end
  end

  assign valid_s[0] = in_valid_q;
  assign stage_s[0] = in_stage_q;

  // round stages
  for (genvar g = 0; g < Stages; g++) begin : g_round
    xtea_round #(
      .Idx   (g / 2),
      .Second(g % 2 == 1)
    ) u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .valid_i  (valid_s[g]),
      .stage_i  (stage_s[g]),
      .key_i    (key_q),
      .rounds_i (rounds_q),
      .valid_o  (valid_s[g+1]),
      .stage_o  (stage_s[g+1])
    );
  end

  // output and skid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= valid_s[Stages];
    end else begin
      skid_valid_q <= valid_s[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_data_q.result_first  <= stage_s[Stages].v0;
      out_data_q.result_second <= stage_s[Stages].v1;
    end else begin
      skid_data_q.result_first  <= stage_s[Stages].v0;
      skid_data_q.result_second <= stage_s[Stages].v1;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;
endmodule
